// File: rtl/core/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int unsigned COL_W       = 7;
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned STATUS_DATA_BIT = 5;

  localparam logic [1:0] EV_UNMARK_OLD = 2'd0;
  localparam logic [1:0] EV_MARK_NEW   = 2'd1;
  localparam logic [1:0] EV_BUTTON     = 2'd2;

  localparam logic [1:0] POS_BUTTONS = 2'd0;
  localparam logic [1:0] POS_DELTA_X = 2'd1;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } mpct_in_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
    logic [1:0]       button_number;
    logic             last;
  } mpct_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]                count;
    mpct_out_t [MAX_RESULTS-1:0]     entries;
  } mpct_batch_t;

endpackage

// File: rtl/core/mpct_decode.sv
// Packet assembly, cursor update and result list generation.
module mpct_decode import mpct_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  mpct_in_t    in_data,
  output mpct_batch_t batch
);

  localparam logic [COL_W-1:0] COL_MAX    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_CENTER = COL_W'(COLUMNS / 2);
  localparam logic [ROW_W-1:0] ROW_CENTER = ROW_W'((ROWS - 1) / 2);

  logic [1:0]       pos_r, pos_nxt;
  logic [7:0]       pkt0_r, pkt1_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [2:0]       btn_r, btn_nxt;

  logic             byte_ok;
  logic             complete;
  logic             moved;
  logic signed [8:0] col_sum;
  logic signed [8:0] row_diff;
  logic [2:0]       btn_new;
  logic [CNT_W-1:0] n;
  mpct_out_t [MAX_RESULTS-1:0] list;

  assign byte_ok  = in_data.status_byte[STATUS_DATA_BIT];
  assign complete = pos_r[1];
  assign btn_new  = pkt0_r[2:0];
  assign moved    = (pkt1_r != 8'd0) || (in_data.data_byte != 8'd0);
  assign col_sum  = $signed({2'b00, col_r}) + $signed({pkt1_r[7], pkt1_r});
  assign row_diff = $signed({4'b0000, row_r})
                  - $signed({in_data.data_byte[7], in_data.data_byte});

  always_comb begin
    if (col_sum < 9'sd0) begin
      col_nxt = '0;
    end else if (col_sum > $signed({2'b00, COL_MAX})) begin
      col_nxt = COL_MAX;
    end else begin
      col_nxt = col_sum[COL_W-1:0];
    end
    if (row_diff < 9'sd0) begin
      row_nxt = '0;
    end else if (row_diff > $signed({4'b0000, ROW_MAX})) begin
      row_nxt = ROW_MAX;
    end else begin
      row_nxt = row_diff[ROW_W-1:0];
    end
  end

  // Compact list: optional unmark/mark pair, then one entry per changed button.
  always_comb begin
    list = '0;
    n    = '0;
    if (moved) begin
      list[0].event_kind  = EV_UNMARK_OLD;
      list[0].cell_column = col_r;
      list[0].cell_row    = row_r;
      list[1].event_kind  = EV_MARK_NEW;
      list[1].cell_column = col_nxt;
      list[1].cell_row    = row_nxt;
      n = CNT_W'(2);
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (btn_new[i] != btn_r[i]) begin
        list[n].event_kind    = EV_BUTTON;
        list[n].cell_column   = moved ? col_nxt : col_r;
        list[n].cell_row      = moved ? row_nxt : row_r;
        list[n].button_number = 2'(i);
        n = n + CNT_W'(1);
      end
    end
    batch.entries = list;
    batch.count   = (byte_ok && complete) ? n : '0;
  end

  always_comb begin
    pos_nxt = pos_r;
    btn_nxt = btn_r;
    if (take && byte_ok) begin
      if (complete) begin
        pos_nxt = '0;
        btn_nxt = btn_new;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      col_r <= COL_CENTER;
      row_r <= ROW_CENTER;
      btn_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      btn_r <= btn_nxt;
      if (take && byte_ok && complete && moved) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_ok && !complete) begin
      if (pos_r == POS_BUTTONS) begin
        pkt0_r <= in_data.data_byte;
      end
      if (pos_r == POS_DELTA_X) begin
        pkt1_r <= in_data.data_byte;
      end
    end
  end

endmodule

// File: rtl/core/mpct_drain.sv
// Result list buffer and output register, one result per cycle while out_stall is low.
module mpct_drain import mpct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  mpct_batch_t batch,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output mpct_out_t   out_data
);

  mpct_out_t [MAX_RESULTS-1:0] list_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  mpct_out_t        out_data_r;

  logic      pending;
  logic      out_load;
  logic      pop;
  logic      is_last;
  mpct_out_t head;

  assign pending  = idx_r != cnt_r;
  assign out_load = !out_valid_r || !out_stall;
  assign pop      = pending && out_load;
  assign is_last  = idx_r == (cnt_r - CNT_W'(1));
  assign in_stall = pending && !(pop && is_last);

  always_comb begin
    head = '0;
    if (pending) begin
      head = list_r[idx_r];
    end
    head.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && batch.count != '0) begin
        cnt_r <= batch.count;
        idx_r <= '0;
      end else if (pop) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && batch.count != '0) begin
      list_r <= batch.entries;
    end
    if (pop) begin
      out_data_r <= head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/mouse_packet_cursor_tracker_unit.sv
// Top level of the mouse packet cursor tracker.
//
// Input channel (in_valid, in_stall, in_data): one request carries a controller
// status byte and a data byte. Bytes with status bit 5 set are gathered into
// three-byte packets (buttons, X delta, Y delta).
// Output channel (out_valid, out_stall, out_data): cell events, one per cycle
// while out_stall is low. A completed packet yields up to five events: unmark
// old cell and mark new cell when the cursor moves, then one button event per
// changed button; the final event of a request has last set.
// The first event of a request passes through the result buffer and then the
// output register. A request that produces events (at most 5) occupies the
// result buffer until its final event is popped; requests without events are
// taken every cycle while no buffered events remain. The next request is
// accepted in the cycle the final event enters the output register.
// Reset: cursor at screen center, buttons released, packet position zero.
// in_stall is high until the final buffered event is popped; when the receiver
// stalls, the output register holds and buffered events wait with in_stall high.
module mouse_packet_cursor_tracker_unit import mpct_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mpct_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mpct_out_t out_data
);

  logic        take;
  mpct_batch_t batch;

  assign take = in_valid && !in_stall;

  mpct_decode #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .batch   (batch)
  );

  mpct_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .batch     (batch),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
